/* hdl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every rising edge, muted while reset is applied
`define OWBM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define OWBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define OWBM_ASSERT(lbl, clk, rst_n, prop, msg)
`define OWBM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hdl/owbm_pkg.sv */
// ----------------------------------------------------------------------------
// owbm_pkg
// Types, command codes, register indexes and reset values of the bus master.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

  // command codes
  localparam logic [2:0] CMD_NONE       = 3'd0;
  localparam logic [2:0] CMD_RESET      = 3'd1;
  localparam logic [2:0] CMD_WRITE_BYTE = 3'd2;
  localparam logic [2:0] CMD_READ_BYTE  = 3'd3;
  localparam logic [2:0] CMD_READ_BIT   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_SHORT_LOW     = 3'd3;
  localparam logic [2:0] REG_SLOT          = 3'd4;
  localparam logic [2:0] REG_SAMPLE_DELAY  = 3'd5;
  localparam logic [2:0] REG_RECOVERY      = 3'd6;
  localparam logic [2:0] REG_BYTE_GAP      = 3'd7;

  // reset values
  localparam logic [15:0] RESET_LOW_DEF     = 16'd2500;
  localparam logic [15:0] PRESENCE_WAIT_DEF = 16'd300;
  localparam logic [15:0] RESET_TAIL_DEF    = 16'd2500;
  localparam logic [15:0] SHORT_LOW_DEF     = 16'd50;
  localparam logic [15:0] SLOT_DEF          = 16'd350;
  localparam logic [15:0] SAMPLE_DELAY_DEF  = 16'd5;
  localparam logic [15:0] RECOVERY_DEF      = 16'd50;
  localparam logic [15:0] BYTE_GAP_DEF      = 16'd500;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       pull_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       read_bit;
  } out_item_t;

  typedef struct packed {
    logic [15:0] reset_low_ticks;
    logic [15:0] presence_wait_ticks;
    logic [15:0] reset_tail_ticks;
    logic [15:0] short_low_ticks;
    logic [15:0] slot_ticks;
    logic [15:0] sample_delay_ticks;
    logic [15:0] recovery_ticks;
    logic [15:0] byte_gap_ticks;
  } cfg_t;

  typedef enum logic [10:0] {
    PH_IDLE     = 11'b000_0000_0001,
    PH_RST_LOW  = 11'b000_0000_0010,
    PH_RST_WAIT = 11'b000_0000_0100,
    PH_RST_TAIL = 11'b000_0000_1000,
    PH_W_LOW    = 11'b000_0001_0000,
    PH_W_HIGH   = 11'b000_0010_0000,
    PH_W_REC    = 11'b000_0100_0000,
    PH_W_GAP    = 11'b000_1000_0000,
    PH_R_LOW    = 11'b001_0000_0000,
    PH_R_WAIT   = 11'b010_0000_0000,
    PH_R_REST   = 11'b100_0000_0000
  } phase_t;

endpackage

`default_nettype wire

/* hdl/owbm_seq.sv */
// ----------------------------------------------------------------------------
// owbm_seq
// Slot sequencer: phase, tick counter, bit index and shift register, one tick
// per step, with the result of that tick presented combinationally.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module owbm_seq (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   step,
  input  owbm_pkg::in_item_t    item,
  input  owbm_pkg::cfg_t        cfg,
  output owbm_pkg::out_item_t   res
);
  import owbm_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        readb_r, readb_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        presence_r, presence_nxt;
  logic        last_bit_r, last_bit_nxt;
  logic [7:0]  held_r, held_nxt;

  logic        start;
  phase_t      cur_phase;
  logic [15:0] cur_tick;
  logic        wbit;
  logic [15:0] len;
  logic [15:0] len_eff;
  logic        last_tick;
  logic        done;
  logic        high_skip;

  always_comb begin
    start = (phase_r == PH_IDLE) &&
            (item.command == CMD_RESET || item.command == CMD_WRITE_BYTE ||
             item.command == CMD_READ_BYTE || item.command == CMD_READ_BIT);

    cur_phase = phase_r;
    readb_nxt = readb_r;
    cur_tick  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    if (start) begin
      readb_nxt = (item.command == CMD_READ_BYTE);
      cur_tick  = 16'd0;
      bit_nxt   = 3'd0;
      case (item.command)
        CMD_RESET: begin
          cur_phase = PH_RST_LOW;
        end
        CMD_WRITE_BYTE: begin
          cur_phase = PH_W_LOW;
          shift_nxt = item.write_byte;
        end
        default: begin
          cur_phase = PH_R_LOW;
          shift_nxt = 8'd0;
        end
      endcase
    end

    wbit      = shift_nxt[bit_nxt];
    high_skip = !wbit || (cfg.short_low_ticks >= cfg.slot_ticks);

    case (cur_phase)
      PH_RST_LOW:  len = cfg.reset_low_ticks;
      PH_RST_WAIT: len = cfg.presence_wait_ticks;
      PH_RST_TAIL: len = cfg.reset_tail_ticks;
      PH_W_LOW:    len = wbit ? cfg.short_low_ticks : cfg.slot_ticks;
      PH_W_HIGH:   len = cfg.slot_ticks - cfg.short_low_ticks;
      PH_W_REC:    len = cfg.recovery_ticks;
      PH_W_GAP:    len = cfg.byte_gap_ticks;
      PH_R_LOW:    len = cfg.short_low_ticks;
      PH_R_WAIT:   len = cfg.sample_delay_ticks;
      PH_R_REST:   len = cfg.slot_ticks;
      default:     len = 16'd1;
    endcase
    // optional phases are skipped on entry when zero; for any other a zero means one tick
    len_eff   = (len == 16'd0) ? 16'd1 : len;
    last_tick = (cur_tick >= (len_eff - 16'd1));

    // samples land on the first tick of the phase after a released wait
    presence_nxt = presence_r;
    last_bit_nxt = last_bit_r;
    if (cur_tick == 16'd0) begin
      if (cur_phase == PH_RST_TAIL) begin
        presence_nxt = !item.line_level;
      end else if (cur_phase == PH_R_REST) begin
        if (readb_nxt) begin
          shift_nxt[bit_nxt] = shift_nxt[bit_nxt] | item.line_level;
        end else begin
          last_bit_nxt = item.line_level;
        end
      end
    end

    phase_nxt = cur_phase;
    tick_nxt  = cur_tick + 16'd1;
    done      = 1'b0;
    held_nxt  = held_r;
    if (cur_phase != PH_IDLE && last_tick) begin
      tick_nxt = 16'd0;
      case (cur_phase)
        PH_RST_LOW: begin
          phase_nxt = (cfg.presence_wait_ticks != 16'd0) ? PH_RST_WAIT : PH_RST_TAIL;
        end
        PH_RST_WAIT: begin
          phase_nxt = PH_RST_TAIL;
        end
        PH_W_LOW, PH_W_HIGH, PH_W_REC: begin
          if (cur_phase == PH_W_LOW && !high_skip) begin
            phase_nxt = PH_W_HIGH;
          end else if (cur_phase != PH_W_REC && cfg.recovery_ticks != 16'd0) begin
            phase_nxt = PH_W_REC;
          end else if (bit_nxt == 3'd7) begin
            phase_nxt = (cfg.byte_gap_ticks != 16'd0) ? PH_W_GAP : PH_IDLE;
          end else begin
            phase_nxt = PH_W_LOW;
            bit_nxt   = bit_nxt + 3'd1;
          end
        end
        PH_R_LOW: begin
          phase_nxt = (cfg.sample_delay_ticks != 16'd0) ? PH_R_WAIT : PH_R_REST;
        end
        PH_R_WAIT: begin
          phase_nxt = PH_R_REST;
        end
        PH_R_REST: begin
          if (readb_nxt && bit_nxt != 3'd7) begin
            phase_nxt = PH_R_LOW;
            bit_nxt   = bit_nxt + 3'd1;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
      done = (phase_nxt == PH_IDLE);
      if (done && readb_nxt) begin
        held_nxt = shift_nxt;
      end
    end else if (cur_phase == PH_IDLE) begin
      tick_nxt = tick_r;
    end

    res.pull_low  = (cur_phase == PH_RST_LOW) || (cur_phase == PH_W_LOW) ||
                    (cur_phase == PH_R_LOW);
    res.busy_res  = (cur_phase != PH_IDLE);
    res.done_res  = done;
    res.presence  = presence_nxt;
    res.read_data = held_nxt;
    res.read_bit  = last_bit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      readb_r    <= 1'b0;
      tick_r     <= 16'd0;
      bit_r      <= 3'd0;
      shift_r    <= 8'd0;
      presence_r <= 1'b0;
      last_bit_r <= 1'b0;
      held_r     <= 8'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      readb_r    <= readb_nxt;
      tick_r     <= tick_nxt;
      bit_r      <= bit_nxt;
      shift_r    <= shift_nxt;
      presence_r <= presence_nxt;
      last_bit_r <= last_bit_nxt;
      held_r     <= held_nxt;
    end
  end

  `OWBM_ASSERT(a_pull_needs_busy, clk, rst_n, res.pull_low |-> res.busy_res, "pull low while not busy")
  `OWBM_ASSERT(a_done_goes_idle, clk, rst_n, (step && res.done_res) |=> (phase_r == PH_IDLE), "done without return to idle")
  `OWBM_ASSERT(a_idle_tick_clear, clk, rst_n, (phase_r == PH_IDLE) |-> (tick_r == 16'd0), "tick counter not cleared in idle")

endmodule

`default_nettype wire

/* hdl/one_wire_bus_master.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Tick-driven bus master: reset/presence, write byte, read byte, read bit.
// ----------------------------------------------------------------------------
// Usage: every transfer on the input channel is one timing tick carrying an
// optional command and the sampled bus level; every tick gives exactly one
// transfer on the result channel with pull_low, busy, a done pulse and the
// held presence, read byte and read bit.
// A tick goes through the input register, the sequencer step (combinational)
// and the result register; throughput is one tick per clock while the
// receiver does not stall. Commands given while a sequence runs, and codes
// above read bit, are ignored. The configuration port takes a write in every
// cycle (ready is always high). Registers must be written only while no
// sequence runs and no tick is in flight; the block does not enforce this.
// Reset restores all slot timings to their defaults, returns the sequencer to
// idle and clears presence, read byte and read bit; no clearing pass. When the
// receiver stalls, the result register holds and the input register still
// takes one more tick before in_stall is raised.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module one_wire_bus_master (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  owbm_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output owbm_pkg::out_item_t   out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [2:0]            cfg_index,
  input  wire  [15:0]           cfg_data
);
  import owbm_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t seq_res;
  logic      proc_fire;
  logic      in_fire;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RESET_LOW:     cfg_nxt.reset_low_ticks     = cfg_data;
        REG_PRESENCE_WAIT: cfg_nxt.presence_wait_ticks = cfg_data;
        REG_RESET_TAIL:    cfg_nxt.reset_tail_ticks    = cfg_data;
        REG_SHORT_LOW:     cfg_nxt.short_low_ticks     = cfg_data;
        REG_SLOT:          cfg_nxt.slot_ticks          = cfg_data;
        REG_SAMPLE_DELAY:  cfg_nxt.sample_delay_ticks  = cfg_data;
        REG_RECOVERY:      cfg_nxt.recovery_ticks      = cfg_data;
        REG_BYTE_GAP:      cfg_nxt.byte_gap_ticks      = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks     <= RESET_LOW_DEF;
      cfg_r.presence_wait_ticks <= PRESENCE_WAIT_DEF;
      cfg_r.reset_tail_ticks    <= RESET_TAIL_DEF;
      cfg_r.short_low_ticks     <= SHORT_LOW_DEF;
      cfg_r.slot_ticks          <= SLOT_DEF;
      cfg_r.sample_delay_ticks  <= SAMPLE_DELAY_DEF;
      cfg_r.recovery_ticks      <= RECOVERY_DEF;
      cfg_r.byte_gap_ticks      <= BYTE_GAP_DEF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // a tick is processed when the result register is free or being drained
  assign proc_fire = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !proc_fire;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_vld_r <= 1'b1;
      end else if (proc_fire) begin
        in_vld_r <= 1'b0;
      end
      if (proc_fire) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r <= in_data;
    end
    if (proc_fire) begin
      out_item_r <= seq_res;
    end
  end

  owbm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (proc_fire),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (seq_res)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  `OWBM_ASSERT(a_stall_needs_item, clk, rst_n, in_stall |-> in_vld_r, "input stalled with empty register")
  `OWBM_ASSERT(a_fire_fills_out, clk, rst_n, proc_fire |=> out_vld_r, "processed tick lost before output")
  `OWBM_ASSERT(a_held_item_kept, clk, rst_n, (in_vld_r && !proc_fire) |=> in_vld_r, "pending tick dropped")

endmodule

`default_nettype wire

/* bench/one_wire_bus_master_tb.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master_tb
// Self-checking bench for the tick-driven bus master. Every input transfer is
// one sequencer tick; a model of the phase sequencer kept in the bench
// predicts the result of each tick, and result transfers are compared with
// it in order. A directed table runs commands under small, zero,
// short-slot and extreme timings, then random ticks run under random small
// timings with sender gaps, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module one_wire_bus_master_tb;
  import owbm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TICKS_PER_SET  = 16;

  // codes the block must treat as no command
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  // timing sets used by the table and the random part
  localparam int KEEP_SET   = -1;
  localparam int SET_ZERO   = 0;
  localparam int SET_MAX    = 1;
  localparam int SET_SHORT  = 2;
  localparam int SET_RANDOM = 3;
  localparam int SET_SMALL  = 4;

  localparam out_item_t IDLE_RES  = '0;
  localparam out_item_t RST_FIRST = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};

  typedef enum logic [1:0] {FILL_LOW, FILL_HIGH, FILL_RANDOM} fill_t;

  typedef struct {
    int         cfg_sel;
    logic [2:0] command;
    logic [7:0] write_byte;
    logic       line_level;
    fill_t      fill;       // bus level on the ticks that follow
    logic [2:0] fill_cmd;   // command offered while the sequence runs
    logic       checked;
    out_item_t  result;
  } dir_row_t;

  dir_row_t dir_rows [22] = '{
    '{KEEP_SET,   CMD_NONE,       8'h00, 1'b1, FILL_HIGH,   CMD_NONE,       1'b1, IDLE_RES},
    '{KEEP_SET,   CMD_UNUSED_LO,  8'hFF, 1'b0, FILL_HIGH,   CMD_NONE,       1'b1, IDLE_RES},
    '{KEEP_SET,   CMD_UNUSED_HI,  8'h00, 1'b1, FILL_HIGH,   CMD_NONE,       1'b1, IDLE_RES},
    '{SET_SMALL,  CMD_RESET,      8'h00, 1'b1, FILL_LOW,    CMD_WRITE_BYTE, 1'b1, RST_FIRST},
    '{KEEP_SET,   CMD_WRITE_BYTE, 8'hA5, 1'b1, FILL_RANDOM, CMD_READ_BYTE,  1'b0, IDLE_RES},
    '{KEEP_SET,   CMD_READ_BYTE,  8'h00, 1'b1, FILL_HIGH,   CMD_NONE,       1'b0, IDLE_RES},
    '{KEEP_SET,   CMD_READ_BYTE,  8'hFF, 1'b0, FILL_RANDOM, CMD_RESET,      1'b0, IDLE_RES},
    '{KEEP_SET,   CMD_READ_BIT,   8'h00, 1'b1, FILL_HIGH,   CMD_NONE,       1'b0, IDLE_RES},
    '{KEEP_SET,   CMD_READ_BIT,   8'h00, 1'b0, FILL_LOW,    CMD_READ_BYTE,  1'b0, IDLE_RES},
    '{KEEP_SET,   CMD_RESET,      8'h00, 1'b1, FILL_HIGH,   CMD_NONE,       1'b0, IDLE_RES},
    '{SET_ZERO,   CMD_RESET,      8'h00, 1'b0, FILL_LOW,    CMD_NONE,       1'b0, IDLE_RES},
    '{KEEP_SET,   CMD_WRITE_BYTE, 8'h00, 1'b1, FILL_RANDOM, CMD_NONE,       1'b0, IDLE_RES},
    '{KEEP_SET,   CMD_WRITE_BYTE, 8'hFF, 1'b0, FILL_RANDOM, CMD_WRITE_BYTE, 1'b0, IDLE_RES},
    '{KEEP_SET,   CMD_READ_BYTE,  8'h00, 1'b1, FILL_RANDOM, CMD_NONE,       1'b0, IDLE_RES},
    '{KEEP_SET,   CMD_READ_BIT,   8'h00, 1'b1, FILL_RANDOM, CMD_READ_BIT,   1'b0, IDLE_RES},
    '{SET_SHORT,  CMD_WRITE_BYTE, 8'hFF, 1'b1, FILL_RANDOM, CMD_NONE,       1'b0, IDLE_RES},
    '{KEEP_SET,   CMD_WRITE_BYTE, 8'h5A, 1'b0, FILL_RANDOM, CMD_NONE,       1'b0, IDLE_RES},
    '{KEEP_SET,   CMD_READ_BYTE,  8'h00, 1'b1, FILL_RANDOM, CMD_NONE,       1'b0, IDLE_RES},
    '{KEEP_SET,   CMD_RESET,      8'h00, 1'b1, FILL_RANDOM, CMD_READ_BIT,   1'b0, IDLE_RES},
    '{SET_MAX,    CMD_READ_BYTE,  8'h80, 1'b1, FILL_RANDOM, CMD_NONE,       1'b0, IDLE_RES},
    '{KEEP_SET,   CMD_READ_BIT,   8'h00, 1'b1, FILL_HIGH,   CMD_NONE,       1'b0, IDLE_RES},
    '{SET_SMALL,  CMD_RESET,      8'h00, 1'b1, FILL_LOW,    CMD_RESET,      1'b0, IDLE_RES}
  };

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // bench copy of the sequencer
  phase_t      ph_q      = PH_IDLE;
  logic [2:0]  op_q      = '0;
  int unsigned tick_q    = 0;
  logic [2:0]  bit_q     = '0;
  logic [7:0]  shift_q   = '0;
  logic        pres_q    = 1'b0;
  logic        lastbit_q = 1'b0;
  logic [7:0]  rbyte_q   = '0;
  logic [15:0] cfg_regs [8];
  logic [15:0] cfg_sets [5][8];

  out_item_t   expected_q [$];
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_ask     = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;

  one_wire_bus_master DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 1 : int'(v);
  endfunction

  // length of a phase under the current timings; 0 means the phase is skipped
  function automatic int unsigned phase_ticks(input phase_t p);
    logic wbit;
    wbit = shift_q[bit_q];
    case (p)
      PH_RST_LOW:  return at_least_one(cfg_regs[REG_RESET_LOW]);
      PH_RST_WAIT: return int'(cfg_regs[REG_PRESENCE_WAIT]);
      PH_RST_TAIL: return at_least_one(cfg_regs[REG_RESET_TAIL]);
      PH_W_LOW:    return at_least_one(wbit ? cfg_regs[REG_SHORT_LOW] : cfg_regs[REG_SLOT]);
      PH_W_HIGH: begin
        if (!wbit || cfg_regs[REG_SHORT_LOW] >= cfg_regs[REG_SLOT]) return 0;
        return int'(cfg_regs[REG_SLOT]) - int'(cfg_regs[REG_SHORT_LOW]);
      end
      PH_W_REC:    return int'(cfg_regs[REG_RECOVERY]);
      PH_W_GAP:    return int'(cfg_regs[REG_BYTE_GAP]);
      PH_R_LOW:    return at_least_one(cfg_regs[REG_SHORT_LOW]);
      PH_R_WAIT:   return int'(cfg_regs[REG_SAMPLE_DELAY]);
      PH_R_REST:   return at_least_one(cfg_regs[REG_SLOT]);
      default:     return 1;
    endcase
  endfunction

  // phase that follows p; moves to the next bit where a slot ends
  function automatic phase_t next_phase(input phase_t p);
    case (p)
      PH_RST_LOW:  return PH_RST_WAIT;
      PH_RST_WAIT: return PH_RST_TAIL;
      PH_W_LOW:    return PH_W_HIGH;
      PH_W_HIGH:   return PH_W_REC;
      PH_W_REC: begin
        if (bit_q == 3'd7) return PH_W_GAP;
        bit_q = bit_q + 3'd1;
        return PH_W_LOW;
      end
      PH_R_LOW:    return PH_R_WAIT;
      PH_R_WAIT:   return PH_R_REST;
      PH_R_REST: begin
        if (op_q == CMD_READ_BYTE && bit_q != 3'd7) begin
          bit_q = bit_q + 3'd1;
          return PH_R_LOW;
        end
        return PH_IDLE;
      end
      default:     return PH_IDLE;
    endcase
  endfunction

  function automatic out_item_t predict_tick(input in_item_t item);
    out_item_t res;
    phase_t    nxt;
    res = '0;
    if (ph_q == PH_IDLE && item.command >= CMD_RESET && item.command <= CMD_READ_BIT) begin
      op_q   = item.command;
      tick_q = 0;
      bit_q  = '0;
      case (item.command)
        CMD_RESET: ph_q = PH_RST_LOW;
        CMD_WRITE_BYTE: begin
          shift_q = item.write_byte;
          ph_q    = PH_W_LOW;
        end
        default: begin
          shift_q = '0;
          ph_q    = PH_R_LOW;
        end
      endcase
    end
    if (ph_q != PH_IDLE) begin
      res.busy_res = 1'b1;
      res.pull_low = (ph_q == PH_RST_LOW || ph_q == PH_W_LOW || ph_q == PH_R_LOW);
      // samples land on the first tick of the phase after a released wait
      if (tick_q == 0) begin
        if (ph_q == PH_RST_TAIL) begin
          pres_q = !item.line_level;
        end else if (ph_q == PH_R_REST) begin
          if (op_q == CMD_READ_BYTE) shift_q = shift_q | (8'(item.line_level) << bit_q);
          else lastbit_q = item.line_level;
        end
      end
      if (tick_q + 1 >= phase_ticks(ph_q)) begin
        nxt = next_phase(ph_q);
        while (nxt != PH_IDLE && phase_ticks(nxt) == 0) nxt = next_phase(nxt);
        ph_q   = nxt;
        tick_q = 0;
        if (nxt == PH_IDLE) begin
          res.done_res = 1'b1;
          if (op_q == CMD_READ_BYTE) rbyte_q = shift_q;
        end
      end else begin
        tick_q = tick_q + 1;
      end
    end
    res.presence  = pres_q;
    res.read_data = rbyte_q;
    res.read_bit  = lastbit_q;
    return res;
  endfunction

  task automatic send_tick(input in_item_t item, input logic use_row, input out_item_t row_res);
    out_item_t pred;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    pred = predict_tick(item);
    expected_q.push_back(use_row ? row_res : pred);
  endtask

  // run the sequencer to idle, let every result out, then load a timing set
  task automatic program_timings(input int sel);
    in_item_t item;
    int       r;
    while (ph_q != PH_IDLE) begin
      item.command    = CMD_NONE;
      item.write_byte = 8'($urandom);
      item.line_level = 1'($urandom_range(1));
      send_tick(item, 1'b0, IDLE_RES);
    end
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (r = REG_RESET_LOW; r <= REG_BYTE_GAP; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(r);
      cfg_data  <= cfg_sets[sel][r];
      do @(posedge clk); while (!cfg_ready);
      cfg_regs[r] = cfg_sets[sel][r];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // receiver: random stalls, or a long hold-off when asked for
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left  = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("pull_low",  8'(want.pull_low),  8'(out_data.pull_low));
        check_field("busy_res",  8'(want.busy_res),  8'(out_data.busy_res));
        check_field("done_res",  8'(want.done_res),  8'(out_data.done_res));
        check_field("presence",  8'(want.presence),  8'(out_data.presence));
        check_field("read_data", want.read_data,     out_data.read_data);
        check_field("read_bit",  8'(want.read_bit),  8'(out_data.read_bit));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_item_t    item;
    int          row;
    int          mode;
    int          k;
    int          r;
    int unsigned pick;

    cfg_regs = '{RESET_LOW_DEF, PRESENCE_WAIT_DEF, RESET_TAIL_DEF, SHORT_LOW_DEF,
                 SLOT_DEF, SAMPLE_DELAY_DEF, RECOVERY_DEF, BYTE_GAP_DEF};
    cfg_sets[SET_ZERO]   = '{default: 16'd0};
    // read slots only, so the long reset and write timings never run out
    cfg_sets[SET_MAX]    = '{16'd65535, 16'd65535, 16'd65535, 16'd1, 16'd2, 16'd0,
                             16'd65535, 16'd65535};
    cfg_sets[SET_SHORT]  = '{16'd1, 16'd1, 16'd1, 16'd2, 16'd2, 16'd0, 16'd0, 16'd1};
    cfg_sets[SET_RANDOM] = '{default: 16'd1};
    cfg_sets[SET_SMALL]  = '{16'd2, 16'd2, 16'd2, 16'd1, 16'd2, 16'd1, 16'd1, 16'd2};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < $size(dir_rows); row++) begin
      if (dir_rows[row].cfg_sel != KEEP_SET) program_timings(dir_rows[row].cfg_sel);
      item.command    = dir_rows[row].command;
      item.write_byte = dir_rows[row].write_byte;
      item.line_level = dir_rows[row].line_level;
      send_tick(item, dir_rows[row].checked, dir_rows[row].result);
      while (ph_q != PH_IDLE) begin
        item.command    = dir_rows[row].fill_cmd;
        item.write_byte = 8'($urandom);
        case (dir_rows[row].fill)
          FILL_LOW:  item.line_level = 1'b0;
          FILL_HIGH: item.line_level = 1'b1;
          default:   item.line_level = 1'($urandom_range(1));
        endcase
        send_tick(item, 1'b0, IDLE_RES);
      end
    end

    for (mode = 0; mode < 4; mode++) begin
      for (k = 0; k < 2; k++) begin
        for (r = REG_RESET_LOW; r <= REG_BYTE_GAP; r++) begin
          cfg_sets[SET_RANDOM][r] = 16'($urandom_range(3));
        end
        program_timings(SET_RANDOM);
        case (mode)
          0:       begin idle_pct = 0;  stall_pct <= 0;  end
          1:       begin idle_pct = 61; stall_pct <= 0;  end
          2:       begin idle_pct = 0;  stall_pct <= 61; end
          default: begin idle_pct = 26; stall_pct <= 26; end
        endcase
        // hold the receiver off while ticks keep coming, so the block backs up
        if (mode == 0 && k == 0) hold_ask <= hold_ask + 1;
        repeat (TICKS_PER_SET) begin
          item.write_byte = 8'($urandom);
          item.line_level = 1'($urandom_range(1));
          pick = $urandom_range(99);
          if (ph_q == PH_IDLE)
            item.command = (pick < 80) ? 3'($urandom_range(CMD_RESET, CMD_READ_BIT))
                                       : 3'($urandom_range(7));
          else
            item.command = (pick < 85) ? CMD_NONE : 3'($urandom_range(7));
          send_tick(item, 1'b0, IDLE_RES);
        end
      end
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/owbm_pkg.sv
hdl/owbm_seq.sv
hdl/one_wire_bus_master.sv
bench/one_wire_bus_master_tb.sv
